>>> src/crc_chk_pkg.sv
`timescale 1ns / 1ps
package crc_chk_pkg;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_MAGIC    = 2'd1,
    STATUS_BAD_VERSION  = 2'd2,
    STATUS_CRC_MISMATCH = 2'd3
  } status_t;

  typedef logic [5:0] pos_t;

  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
  localparam logic [7:0]  MAGIC_FIRST  = 8'h43;
  localparam logic [7:0]  MAGIC_SECOND = 8'h42;

  localparam pos_t PAYLOAD_LEN = 6'd48;
  localparam pos_t TOTAL_LEN   = 6'd52;
  localparam pos_t LAST_POS    = 6'd51;
  localparam pos_t HEADER_LEN  = 6'd3;
  localparam pos_t NAME_FIRST  = 6'd4;
  localparam pos_t NAME_END    = 6'd24;
  localparam pos_t VALUE_FIRST = 6'd24;

  localparam int NAME_LEN   = 20;
  localparam int VALUE_LEN  = 24;

endpackage

>>> src/crc_chk_crc_byte.sv
`timescale 1ns / 1ps
module crc_chk_crc_byte
  import crc_chk_pkg::*;
(
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

>>> src/card_record_checker.sv
`timescale 1ns / 1ps
// The checker takes one record byte per cycle when not stalled: 48 payload bytes and then the
// stored CRC-32, least significant byte first. Each payload byte is folded into the CRC by a
// byte-wide update in the cycle of its transfer, so the sustained rate is one byte per cycle
// while the input does not stall. The result appears in the output register in the cycle after
// the last byte is taken; the input stalls only when that last byte arrives while the previous
// result is still waiting to be taken. A restart byte begins a new record at once.
module card_record_checker
  import crc_chk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_format_version,
  output logic [63:0] out_name_low,
  output logic [63:0] out_name_mid,
  output logic [31:0] out_name_high,
  output logic [63:0] out_balance,
  output logic [63:0] out_transactions,
  output logic [63:0] out_games_won,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0]  expected_version_r;
  pos_t        pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crc_base, crc_upd;
  logic [7:0]  hdr_r  [HEADER_LEN];
  logic [7:0]  name_r [NAME_LEN];
  logic [7:0]  value_r[VALUE_LEN];
  logic [23:0] rx_r;

  logic        acc;
  pos_t        pos_eff;
  pos_t        name_idx, value_idx, rx_idx;
  logic        res_valid;
  status_t     res_status;

  logic        out_valid_r;
  status_t     out_status_r;
  logic [7:0]  out_version_r;
  logic [63:0] out_name_low_r, out_name_mid_r;
  logic [31:0] out_name_high_r;
  logic [63:0] out_balance_r, out_trans_r, out_games_r;

  logic [159:0] name_flat;
  logic [191:0] value_flat;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall && (pos_r == LAST_POS);
  assign acc       = in_valid && !in_stall;
  assign pos_eff   = in_restart ? '0 : pos_r;
  assign crc_base  = in_restart ? CRC_INIT : crc_r;
  assign name_idx  = pos_eff - NAME_FIRST;
  assign value_idx = pos_eff - VALUE_FIRST;
  assign rx_idx    = pos_eff - PAYLOAD_LEN;

  crc_chk_crc_byte u_crc (
    .crc_in  (crc_base),
    .data    (in_data_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    if ((hdr_r[0] != MAGIC_FIRST) || (hdr_r[1] != MAGIC_SECOND)) begin
      res_status = STATUS_BAD_MAGIC;
    end else if (hdr_r[2] != expected_version_r) begin
      res_status = STATUS_BAD_VERSION;
    end else if (~crc_r != {in_data_byte, rx_r}) begin
      res_status = STATUS_CRC_MISMATCH;
    end else begin
      res_status = STATUS_OK;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    res_valid = 1'b0;
    if (acc) begin
      if (pos_eff >= TOTAL_LEN) begin
        pos_nxt = '0;
        crc_nxt = CRC_INIT;
      end else if (pos_eff < PAYLOAD_LEN) begin
        pos_nxt = pos_eff + 6'd1;
        crc_nxt = crc_upd;
      end else if (pos_eff < LAST_POS) begin
        pos_nxt = pos_eff + 6'd1;
        crc_nxt = crc_base;
      end else begin
        pos_nxt   = '0;
        crc_nxt   = CRC_INIT;
        res_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r              <= '0;
      crc_r              <= CRC_INIT;
      expected_version_r <= 8'd1;
      out_valid_r        <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      if (cfg_valid && cfg_ready) begin
        expected_version_r <= cfg_data;
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (pos_eff < HEADER_LEN) begin
        hdr_r[pos_eff[1:0]] <= in_data_byte;
      end else if ((pos_eff >= NAME_FIRST) && (pos_eff < NAME_END)) begin
        name_r[name_idx[4:0]] <= in_data_byte;
      end else if ((pos_eff >= VALUE_FIRST) && (pos_eff < PAYLOAD_LEN)) begin
        value_r[value_idx[4:0]] <= in_data_byte;
      end else if ((pos_eff >= PAYLOAD_LEN) && (pos_eff < LAST_POS)) begin
        rx_r[rx_idx[1:0]*8 +: 8] <= in_data_byte;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NAME_LEN; i++) begin
      name_flat[i*8 +: 8] = name_r[i];
    end
    for (int i = 0; i < VALUE_LEN; i++) begin
      value_flat[i*8 +: 8] = value_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_status_r <= res_status;
      if (res_status == STATUS_OK) begin
        out_version_r   <= hdr_r[2];
        out_name_low_r  <= name_flat[63:0];
        out_name_mid_r  <= name_flat[127:64];
        out_name_high_r <= name_flat[159:128];
        out_balance_r   <= value_flat[63:0];
        out_trans_r     <= value_flat[127:64];
        out_games_r     <= value_flat[191:128];
      end else begin
        out_version_r   <= '0;
        out_name_low_r  <= '0;
        out_name_mid_r  <= '0;
        out_name_high_r <= '0;
        out_balance_r   <= '0;
        out_trans_r     <= '0;
        out_games_r     <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_format_version = out_version_r;
  assign out_name_low       = out_name_low_r;
  assign out_name_mid       = out_name_mid_r;
  assign out_name_high      = out_name_high_r;
  assign out_balance        = out_balance_r;
  assign out_transactions   = out_trans_r;
  assign out_games_won      = out_games_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("Byte position left the record.");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_restart && (pos_r == LAST_POS)) |=> out_valid)
    else $error("Last byte transfer produced no result.");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("Input stalled with an empty result register.");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STATUS_OK)) |->
      ((out_format_version == 8'd0) && (out_balance == 64'd0) && (out_name_low == 64'd0)))
    else $error("Decoded fields not cleared on a failed record.");

endmodule
